/* hw/rtl/sfr_pkg.sv */
// shared types and constants for the stream find-and-replace block
// no dependencies
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int BURST_BYTES = 8;
   localparam int BURST_W     = BURST_BYTES * BYTE_W;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_BYTES = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_LEN   = CSR_IDX_W'(3);

   localparam logic [LEN_W-1:0] MAX_REPL = LEN_W'(BURST_BYTES);

   typedef struct packed {
      logic en;
      logic write_here;
      logic shift;
      logic active;
   } cell_ctrl_type;

   typedef struct packed {
      logic             en;
      logic             shift;
      logic [LEN_W-1:0] slot;
      logic [LEN_W-1:0] plen;
   } win_ctrl_type;

   typedef struct packed {
      logic               load;
      logic [BURST_W-1:0] data;
      logic [LEN_W-1:0]   count;
      logic               last;
      logic               bare;
   } burst_load_type;

endpackage

`default_nettype wire

/* hw/rtl/sfr_cell.sv */
// one window cell: holds a pending byte, compares it against its pattern byte
// depends on sfr_pkg
`default_nettype none

module sfr_cell (
   input  logic                       clock,
   input  sfr_pkg::cell_ctrl_type     ctrl,
   input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
   input  logic [sfr_pkg::BYTE_W-1:0] pattern_byte,
   input  logic [sfr_pkg::BYTE_W-1:0] right_byte,
   input  logic                       match_in,
   output logic [sfr_pkg::BYTE_W-1:0] merged_byte,
   output logic                       match_out
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   assign merged_byte = ctrl.write_here ? in_byte : byte_ff;
   assign match_out   = match_in & (!ctrl.active | (merged_byte == pattern_byte));
   assign byte_in     = ctrl.shift ? right_byte : merged_byte;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sfr_window.sv */
// pending-byte window built as a row of cells with a chained match
// depends on sfr_pkg and sfr_cell
`default_nettype none

module sfr_window #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                                   clock,
   input  sfr_pkg::win_ctrl_type                  ctrl,
   input  logic [sfr_pkg::BYTE_W-1:0]             in_byte,
   input  logic [MAX_PATTERN*sfr_pkg::BYTE_W-1:0] pattern_bytes,
   output logic [MAX_PATTERN*sfr_pkg::BYTE_W-1:0] merged_bytes,
   output logic                                   match
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] merged_a [MAX_PATTERN];
   logic [BYTE_W-1:0] right_a  [MAX_PATTERN];
   logic              chain_a  [MAX_PATTERN+1];

   assign chain_a[0] = 1'b1;
   assign match      = chain_a[MAX_PATTERN];

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      cell_ctrl_type cc;

      assign cc.en         = ctrl.en;
      assign cc.write_here = (ctrl.slot == LEN_W'(i));
      assign cc.shift      = ctrl.shift;
      assign cc.active     = (LEN_W'(i) < ctrl.plen);

      if (i == MAX_PATTERN - 1) begin : g_end
         assign right_a[i] = '0;
      end else begin : g_mid
         assign right_a[i] = merged_a[i+1];
      end

      assign merged_bytes[i*BYTE_W +: BYTE_W] = merged_a[i];

      sfr_cell u_cell (
         .clock        (clock),
         .ctrl         (cc),
         .in_byte      (in_byte),
         .pattern_byte (pattern_bytes[i*BYTE_W +: BYTE_W]),
         .right_byte   (right_a[i]),
         .match_in     (chain_a[i]),
         .merged_byte  (merged_a[i]),
         .match_out    (chain_a[i+1])
      );
   end

endmodule

`default_nettype wire

/* hw/rtl/sfr_burst.sv */
// output shift register that hands out the results of one input beat
// depends on sfr_pkg
`default_nettype none

module sfr_burst (
   input  logic                       clock,
   input  logic                       reset,
   input  sfr_pkg::burst_load_type    load,
   output logic                       can_load,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [sfr_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   import sfr_pkg::*;

   logic [BURST_W-1:0] data_ff;
   logic [LEN_W-1:0]   rem_ff;
   logic               last_ff;
   logic               bare_ff;

   assign rsp_tvalid = (rem_ff != '0);
   assign can_load   = (rem_ff == '0) || ((rem_ff == LEN_W'(1)) && rsp_tready);
   assign rsp_tdata  = data_ff[BYTE_W-1:0];
   assign rsp_tuser  = !bare_ff;
   assign rsp_tlast  = last_ff && (rem_ff == LEN_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (load.load) begin
         data_ff <= load.bare ? '0 : load.data;
         rem_ff  <= load.bare ? LEN_W'(1) : load.count;
         last_ff <= load.last;
         bare_ff <= load.bare;
      end else if (rsp_tvalid && rsp_tready) begin
         data_ff <= data_ff >> BYTE_W;
         rem_ff  <= rem_ff - LEN_W'(1);
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/stream_find_replace_top.sv */
// stream find-and-replace: first result of a beat shows in the cycle after it is taken
// one input beat per cycle while each beat yields at most one result and the output is
// not stalled; a beat that yields more results holds req_tready low as the output drains
// sync reset clears config to zero, empties the window and the output register
// depends on sfr_pkg, sfr_window, sfr_burst
`default_nettype none

module stream_find_replace_top #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sfr_pkg::BYTE_W-1:0]     req_tdata,   // in_byte
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfr_pkg::BYTE_W-1:0]     rsp_tdata,   // out_byte
   output logic                           rsp_tuser,   // byte_valid
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_data
);
   import sfr_pkg::*;

   localparam int                WIN_W   = MAX_PATTERN * BYTE_W;
   localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_PATTERN);

   logic [CSR_DATA_W-1:0] pattern_ff;
   logic [LEN_W-1:0]      plen_cfg_ff;
   logic [CSR_DATA_W-1:0] repl_ff;
   logic [LEN_W-1:0]      rlen_cfg_ff;
   logic [LEN_W-1:0]      fill_ff;
   logic [LEN_W-1:0]      fill_in;

   logic [LEN_W-1:0] plen;
   logic [LEN_W-1:0] rlen;
   logic [LEN_W-1:0] fill_eff;
   logic [LEN_W-1:0] fill_up;
   logic             full;
   logic             accept;
   logic             match;
   logic [WIN_W-1:0] merged;

   win_ctrl_type   win_ctrl;
   burst_load_type burst;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   assign plen     = (plen_cfg_ff > MAX_LEN) ? MAX_LEN : plen_cfg_ff;
   assign rlen     = (rlen_cfg_ff > MAX_REPL) ? MAX_REPL : rlen_cfg_ff;
   assign fill_eff = (fill_ff >= plen) ? '0 : fill_ff;
   assign fill_up  = fill_eff + LEN_W'(1);
   assign full     = (plen != '0) && (fill_up == plen);

   assign win_ctrl.en    = accept && (plen != '0);
   assign win_ctrl.shift = full && !match;
   assign win_ctrl.slot  = fill_eff;
   assign win_ctrl.plen  = plen;

   sfr_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock         (clock),
      .ctrl          (win_ctrl),
      .in_byte       (req_tdata),
      .pattern_bytes (pattern_ff[WIN_W-1:0]),
      .merged_bytes  (merged),
      .match         (match)
   );

   always_comb begin
      burst.load  = accept;
      burst.last  = req_tlast;
      burst.data  = BURST_W'(merged);
      burst.count = '0;
      fill_in     = fill_up;
      priority if (plen == '0) begin
         burst.data  = BURST_W'(req_tdata);
         burst.count = LEN_W'(1);
         fill_in     = '0;
      end else if (full && match) begin
         burst.data  = repl_ff;
         burst.count = rlen;
         fill_in     = '0;
      end else if (full) begin
         burst.count = req_tlast ? plen : LEN_W'(1);
         fill_in     = plen - LEN_W'(1);
      end else begin
         burst.count = req_tlast ? fill_up : '0;
      end
      if (req_tlast) begin
         fill_in = '0;
      end
      burst.bare = req_tlast && (burst.count == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         plen_cfg_ff <= '0;
         repl_ff     <= '0;
         rlen_cfg_ff <= '0;
         fill_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PATTERN_BYTES: begin
               pattern_ff <= csr_data;
               fill_ff    <= '0;
            end
            REG_PATTERN_LEN: begin
               plen_cfg_ff <= csr_data[LEN_W-1:0];
               fill_ff     <= '0;
            end
            REG_REPLACEMENT_BYTES: begin
               repl_ff <= csr_data;
               fill_ff <= '0;
            end
            REG_REPLACEMENT_LEN: begin
               rlen_cfg_ff <= csr_data[LEN_W-1:0];
               fill_ff     <= '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   sfr_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (burst),
      .can_load   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* hw/rtl/sfr_checker.sv */
// port-level assertions for the find-and-replace top level, with its bind
// depends on sfr_pkg and stream_find_replace_top
`default_nettype none

module sfr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [sfr_pkg::BYTE_W-1:0] rsp_tdata,
   input logic                       rsp_tuser,
   input logic                       rsp_tlast
);
   import sfr_pkg::*;

   // bare end marker is always the final beat and carries a zero byte
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("bare end marker malformed");

   // input only stalls while results are pending
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
